FILE: rtl/tfrf_pkg.sv
package tfrf_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int FRAMES_W    = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LEN_W-1:0]    MAX_LEN_RESET  = 6'd32;
  localparam logic [BYTE_W-1:0]   TERM_RESET     = 8'd13;
  localparam logic [FRAMES_W-1:0] FRAMES_SAT     = 6'd63;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_FRAME_LENGTH = 1'b0;
  localparam logic REG_TERMINATOR_BYTE  = 1'b1;

  // Function codes of an input request.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_GET  = 1'b1;

  typedef enum logic [2:0] {
    CODE_NO_FRAME    = 3'd0,
    CODE_DATA        = 3'd1,
    CODE_GOT_FRAME   = 3'd2,
    CODE_FRAME_ERROR = 3'd3,
    CODE_TOO_LARGE   = 3'd4
  } code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOFRAME,
    ST_POP
  } state_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    code_t             code;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    logic  frame_done;
    logic  len_clear;
    logic  emit;
    code_t code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frames_zero;
    logic queue_empty;
    logic limit_hit;
    logic term_hit;
  } status_t;

endpackage

FILE: rtl/tfrf_ram.sv
module tfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tfrf_regs.sv
module tfrf_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tfrf_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [tfrf_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [tfrf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output logic [tfrf_pkg::LEN_W-1:0]            max_frame_length,
  output logic [tfrf_pkg::BYTE_W-1:0]           terminator_byte
);

  logic [tfrf_pkg::LEN_W-1:0]  max_len_r, max_len_nxt;
  logic [tfrf_pkg::BYTE_W-1:0] term_r, term_nxt;
  logic                        wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    max_len_nxt = max_len_r;
    term_nxt    = term_r;
    if (wr_en) begin
      unique case (paddr[2])
        tfrf_pkg::REG_MAX_FRAME_LENGTH: max_len_nxt = pwdata[tfrf_pkg::LEN_W-1:0];
        tfrf_pkg::REG_TERMINATOR_BYTE:  term_nxt    = pwdata[tfrf_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= tfrf_pkg::MAX_LEN_RESET;
      term_r    <= tfrf_pkg::TERM_RESET;
    end else begin
      max_len_r <= max_len_nxt;
      term_r    <= term_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      tfrf_pkg::REG_MAX_FRAME_LENGTH:
        prdata = {{(tfrf_pkg::CFG_DATA_W-tfrf_pkg::LEN_W){1'b0}}, max_len_r};
      tfrf_pkg::REG_TERMINATOR_BYTE:
        prdata = {{(tfrf_pkg::CFG_DATA_W-tfrf_pkg::BYTE_W){1'b0}}, term_r};
      default: prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign max_frame_length = max_len_r;
  assign terminator_byte  = term_r;

endmodule

FILE: rtl/tfrf_ctrl.sv
module tfrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              func,
  input  tfrf_pkg::status_t status,
  output tfrf_pkg::cmd_t    cmd,
  output logic              busy
);

  tfrf_pkg::state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfrf_pkg::ST_IDLE: begin
        if (start && func == tfrf_pkg::FUNC_GET) begin
          state_nxt = status.frames_zero ? tfrf_pkg::ST_NOFRAME : tfrf_pkg::ST_POP;
        end
      end
      tfrf_pkg::ST_NOFRAME: state_nxt = tfrf_pkg::ST_IDLE;
      tfrf_pkg::ST_POP: begin
        if (status.queue_empty || status.limit_hit || status.term_hit) begin
          state_nxt = tfrf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfrf_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd  = '0;
    cmd.code = tfrf_pkg::CODE_NO_FRAME;
    busy = 1'b1;
    unique case (state_r)
      tfrf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.push      = (func == tfrf_pkg::FUNC_PUSH);
          cmd.len_clear = (func == tfrf_pkg::FUNC_GET);
        end
      end
      tfrf_pkg::ST_NOFRAME: begin
        cmd.emit = 1'b1;
        cmd.code = tfrf_pkg::CODE_NO_FRAME;
      end
      tfrf_pkg::ST_POP: begin
        cmd.emit = 1'b1;
        priority if (status.queue_empty) begin
          cmd.clear = 1'b1;
          cmd.code  = tfrf_pkg::CODE_FRAME_ERROR;
        end else if (status.limit_hit) begin
          cmd.pop   = 1'b1;
          cmd.clear = 1'b1;
          cmd.code  = tfrf_pkg::CODE_TOO_LARGE;
        end else if (status.term_hit) begin
          cmd.pop        = 1'b1;
          cmd.frame_done = 1'b1;
          cmd.code       = tfrf_pkg::CODE_GOT_FRAME;
        end else begin
          cmd.pop  = 1'b1;
          cmd.code = tfrf_pkg::CODE_DATA;
        end
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tfrf_datapath.sv
module tfrf_datapath #(
  parameter int QUEUE_DEPTH = tfrf_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tfrf_pkg::in_t               in_data,
  input  tfrf_pkg::cmd_t              cmd,
  input  logic [tfrf_pkg::LEN_W-1:0]  max_frame_length,
  input  logic [tfrf_pkg::BYTE_W-1:0] terminator_byte,
  output tfrf_pkg::status_t           status,
  output logic                        out_valid,
  output tfrf_pkg::out_t              out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [tfrf_pkg::FRAMES_W-1:0] frames_r, frames_nxt;
  logic [tfrf_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [tfrf_pkg::LEN_W:0]      len_inc;
  logic [tfrf_pkg::BYTE_W-1:0]   rdata;
  logic                          full;
  logic                          wr_en;

  assign full    = (fill_r == FULL_CNT);
  assign wr_en   = cmd.push && !full;
  assign len_inc = {1'b0, len_r} + 1'b1;

  assign status.frames_zero = (frames_r == '0);
  assign status.queue_empty = (fill_r == '0);
  assign status.limit_hit   = (len_inc >= {1'b0, max_frame_length});
  assign status.term_hit    = (rdata == terminator_byte);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    frames_nxt = frames_r;
    len_nxt    = len_r;
    if (cmd.len_clear) begin
      len_nxt = '0;
    end else if (cmd.pop) begin
      len_nxt = len_inc[tfrf_pkg::LEN_W-1:0];
    end
    if (cmd.clear) begin
      // An error drops everything queued; stored bytes stay in the RAM.
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      fill_nxt   = '0;
      frames_nxt = '0;
    end else begin
      if (wr_en) begin
        wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
        fill_nxt   = fill_r + 1'b1;
        if (in_data.rx_byte == terminator_byte && frames_r != tfrf_pkg::FRAMES_SAT) begin
          frames_nxt = frames_r + 1'b1;
        end
      end
      if (cmd.pop) begin
        rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
        fill_nxt   = fill_r - 1'b1;
      end
      if (cmd.frame_done) begin
        frames_nxt = frames_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      frames_r <= '0;
      len_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      frames_r <= frames_nxt;
      len_r    <= len_nxt;
    end
  end

  // The read address follows the next read pointer, so the head byte is
  // always waiting in the RAM output register.
  tfrf_ram #(
    .WIDTH (tfrf_pkg::BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata (in_data.rx_byte),
    .raddr (rd_ptr_nxt),
    .rdata (rdata)
  );

  assign out_valid             = cmd.emit;
  assign out_data.code         = cmd.code;
  assign out_data.frame_byte   = (cmd.code == tfrf_pkg::CODE_DATA) ? rdata : '0;
  assign out_data.frame_length = (cmd.code == tfrf_pkg::CODE_GOT_FRAME) ? len_r : '0;
  assign out_data.last         = (cmd.code != tfrf_pkg::CODE_DATA);

endmodule

FILE: rtl/terminated_frame_receive_fifo.sv
// Receive queue for serial bytes that are read back as frames closed by a
// terminator byte.
// Input channel: a request is taken on a rising edge where start is high and
// busy is low. A push request (func 0) stores rx_byte in the same edge and
// gives no result; it never raises busy, so pushes may arrive every cycle
// while no get holds busy. A byte pushed into a full queue is dropped.
// A get request (func 1) raises busy and produces results on out_valid, one
// per cycle, starting the cycle after the request. With no complete frame it
// gives a single no-frame result. Otherwise one result per popped byte is
// given: data bytes, then got frame with the length, or too large; or a
// frame error, which pops nothing, when the queue runs dry. Busy falls at
// the edge that takes the result carrying last, so a get request holds the
// input until that result is taken.
// The pop rate of one byte per cycle is set by the queue RAM, whose read
// port is addressed with the next read pointer so the head byte is ready.
// The result channel cannot be stalled; each result is valid for one cycle.
// Reset (synchronous, active low) empties the queue, clears the frame count
// and loads the registers: frame limit 32, terminator 13. The queue RAM
// itself is not cleared, only entries counted as filled are ever read.
// Configuration is written over the APB port at byte addresses 0 and 4.
module terminated_frame_receive_fifo #(
  parameter int QUEUE_DEPTH = tfrf_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input request channel.
  input  logic                              start,
  output logic                              busy,
  input  tfrf_pkg::in_t                     in_data,
  // Result channel.
  output logic                              out_valid,
  output tfrf_pkg::out_t                    out_data,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tfrf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tfrf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tfrf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  tfrf_pkg::cmd_t              cmd;
  tfrf_pkg::status_t           status;
  logic [tfrf_pkg::LEN_W-1:0]  max_frame_length;
  logic [tfrf_pkg::BYTE_W-1:0] terminator_byte;

  // Configuration registers.
  tfrf_regs u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .max_frame_length (max_frame_length),
    .terminator_byte  (terminator_byte)
  );

  // The controller sequences a get request one popped byte per cycle.
  tfrf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_data.func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the queue, its pointers and counters, and forms the
  // result fields.
  tfrf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .cmd              (cmd),
    .max_frame_length (max_frame_length),
    .terminator_byte  (terminator_byte),
    .status           (status),
    .out_valid        (out_valid),
    .out_data         (out_data)
  );

endmodule

FILE: dv/tfrf_frame_checker.sv
module tfrf_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  tfrf_pkg::in_t                       in_data,
  input  logic                                out_valid,
  input  tfrf_pkg::out_t                      out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tfrf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tfrf_pkg::CFG_DATA_W-1:0]     pwdata,
  input  logic [tfrf_pkg::CFG_DATA_W-1:0]     prdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  owed_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the receive queue and its registers.
  logic [tfrf_pkg::BYTE_W-1:0] ring [tfrf_pkg::QUEUE_DEPTH];
  int                          rd_ptr;
  int                          wr_ptr;
  int                          fill;
  int                          frames;
  logic [tfrf_pkg::LEN_W-1:0]  frame_limit;
  logic [tfrf_pkg::BYTE_W-1:0] term_byte;

  // Results the block still owes, oldest first.
  tfrf_pkg::out_t owed_results[$];
  int             errors = 0;

  function automatic tfrf_pkg::out_t frame_result(logic [tfrf_pkg::BYTE_W-1:0] b,
                                                  tfrf_pkg::code_t c,
                                                  logic [tfrf_pkg::LEN_W-1:0] len,
                                                  logic lst);
    tfrf_pkg::out_t r;
    r.frame_byte   = b;
    r.code         = c;
    r.frame_length = len;
    r.last         = lst;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void empty_queue();
    rd_ptr = 0;
    wr_ptr = 0;
    fill   = 0;
    frames = 0;
  endfunction

  // Applies one accepted request and queues the results it causes.
  task automatic advance_rx_queue(tfrf_pkg::in_t req);
    int                          length;
    logic [tfrf_pkg::BYTE_W-1:0] b;
    bit                          done;
    if (req.func == tfrf_pkg::FUNC_PUSH) begin
      if (fill < tfrf_pkg::QUEUE_DEPTH) begin
        ring[wr_ptr] = req.rx_byte;
        wr_ptr = (wr_ptr + 1) % tfrf_pkg::QUEUE_DEPTH;
        fill++;
        if (req.rx_byte == term_byte && frames < int'(tfrf_pkg::FRAMES_SAT)) frames++;
      end
    end else if (frames == 0) begin
      owed_results.push_back(frame_result('0, tfrf_pkg::CODE_NO_FRAME, '0, 1'b1));
    end else begin
      length = 0;
      done   = 1'b0;
      while (!done) begin
        if (fill == 0) begin
          empty_queue();
          owed_results.push_back(frame_result('0, tfrf_pkg::CODE_FRAME_ERROR, '0, 1'b1));
          done = 1'b1;
        end else begin
          b = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % tfrf_pkg::QUEUE_DEPTH;
          fill--;
          length++;
          if (length >= int'(frame_limit)) begin
            empty_queue();
            owed_results.push_back(frame_result('0, tfrf_pkg::CODE_TOO_LARGE, '0, 1'b1));
            done = 1'b1;
          end else if (b == term_byte) begin
            frames--;
            owed_results.push_back(frame_result('0, tfrf_pkg::CODE_GOT_FRAME,
                                                tfrf_pkg::LEN_W'(length - 1), 1'b1));
            done = 1'b1;
          end else begin
            owed_results.push_back(frame_result(b, tfrf_pkg::CODE_DATA, '0, 1'b0));
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    tfrf_pkg::out_t                  want;
    logic [tfrf_pkg::CFG_DATA_W-1:0] reg_value;
    if (!rst_n) begin
      empty_queue();
      frame_limit = tfrf_pkg::MAX_LEN_RESET;
      term_byte   = tfrf_pkg::TERM_RESET;
      owed_results.delete();
    end else begin
      // Results are taken before requests: a request accepted at this edge
      // only causes results at later edges.
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with none owed, code", int'(out_data.code), -1);
        end else begin
          want = owed_results.pop_front();
          if (out_data.frame_byte !== want.frame_byte)
            report_mismatch("frame_byte", int'(out_data.frame_byte),
                            int'(want.frame_byte));
          if (out_data.code !== want.code)
            report_mismatch("code", int'(out_data.code), int'(want.code));
          if (out_data.frame_length !== want.frame_length)
            report_mismatch("frame_length", int'(out_data.frame_length),
                            int'(want.frame_length));
          if (out_data.last !== want.last)
            report_mismatch("last", int'(out_data.last), int'(want.last));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[tfrf_pkg::CFG_ADDR_W-1] == tfrf_pkg::REG_MAX_FRAME_LENGTH)
            frame_limit = pwdata[tfrf_pkg::LEN_W-1:0];
          else
            term_byte = pwdata[tfrf_pkg::BYTE_W-1:0];
        end else begin
          if (paddr[tfrf_pkg::CFG_ADDR_W-1] == tfrf_pkg::REG_MAX_FRAME_LENGTH)
            reg_value = tfrf_pkg::CFG_DATA_W'(frame_limit);
          else
            reg_value = tfrf_pkg::CFG_DATA_W'(term_byte);
          if (prdata !== reg_value)
            report_mismatch("register readback", int'(prdata), int'(reg_value));
        end
      end
      if (start && !busy) advance_rx_queue(in_data);
    end
    fail_count <= errors;
    owed_count <= owed_results.size();
  end

endmodule

FILE: dv/terminated_frame_receive_fifo_test.sv
module terminated_frame_receive_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  // A run with no accepted request, result or register access until the idle
  // count reaches this limit is taken as hung. The longest quiet stretch of a
  // correct run is a long sender gap or a register phase.
  localparam int IDLE_LIMIT = 1000;

  // Approximate number of requests the run sends before it winds down.
  localparam int REQUEST_TARGET = 320;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            start     = 1'b0;
  logic                            busy;
  tfrf_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  tfrf_pkg::out_t                  out_data;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [tfrf_pkg::CFG_ADDR_W-1:0] paddr     = '0;
  logic [tfrf_pkg::CFG_DATA_W-1:0] pwdata    = '0;
  logic [tfrf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int fail_count;
  int owed_count;
  int idle_cycles   = 0;
  int requests_sent = 0;

  // Terminator as last written, so that the stimulus can build frames.
  logic [tfrf_pkg::BYTE_W-1:0] cur_term = tfrf_pkg::TERM_RESET;

  // When set, the sender sends back to back for the whole phase.
  bit no_gaps = 1'b0;

  always #1 clk = ~clk;

  terminated_frame_receive_fifo u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tfrf_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  // Watchdog. Every process here drives with nonblocking assignments, so the
  // values read at the edge are the ones from before it.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Random sender gap: mostly none, sometimes a short one, rarely a long
  // one. While idle the payload carries junk to show that it is ignored.
  task automatic pause_sender();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55)
      n = 0;
    else if (r < 90)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(8, 40);
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= tfrf_pkg::in_t'(9'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  // Presents one request and holds it until an edge where busy is low.
  // Start is left high, so a following request goes out with no gap.
  task automatic send_request(logic func, logic [tfrf_pkg::BYTE_W-1:0] b);
    tfrf_pkg::in_t req;
    req.func    = func;
    req.rx_byte = b;
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    requests_sent++;
    pause_sender();
  endtask

  task automatic push_byte(logic [tfrf_pkg::BYTE_W-1:0] b);
    send_request(tfrf_pkg::FUNC_PUSH, b);
  endtask

  // The byte field of a frame request is don't-care, so it gets junk.
  task automatic request_frame();
    send_request(tfrf_pkg::FUNC_GET, 8'($urandom));
  endtask

  // Waits until every owed result has come, then waits on so that a push
  // that causes no result has surely settled in the queue.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle held until pready, then an
  // idle phase so that back-to-back transfers never assign psel twice in a
  // single step.
  task automatic apb_access(logic wr, logic idx, logic [tfrf_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register; the bits above its width carry junk.
  task automatic set_register(logic idx, logic [tfrf_pkg::BYTE_W-1:0] value);
    logic [tfrf_pkg::CFG_DATA_W-1:0] data;
    data = $urandom;
    if (idx == tfrf_pkg::REG_MAX_FRAME_LENGTH) begin
      data[tfrf_pkg::LEN_W-1:0] = value[tfrf_pkg::LEN_W-1:0];
    end else begin
      data[tfrf_pkg::BYTE_W-1:0] = value;
      cur_term = value;
    end
    apb_access(1'b1, idx, data);
  endtask

  task automatic read_registers();
    apb_access(1'b0, tfrf_pkg::REG_MAX_FRAME_LENGTH, '0);
    apb_access(1'b0, tfrf_pkg::REG_TERMINATOR_BYTE, '0);
  endtask

  // Brings the queue to a known empty state. With a limit of one, any frame
  // request ends in too large on its first pop, which clears the queue and
  // the frame count; the pushed terminator makes sure a frame is counted.
  task automatic flush_queue(logic [tfrf_pkg::LEN_W-1:0] next_limit);
    settle();
    set_register(tfrf_pkg::REG_MAX_FRAME_LENGTH, 8'd1);
    push_byte(cur_term);
    request_frame();
    settle();
    set_register(tfrf_pkg::REG_MAX_FRAME_LENGTH, 8'(next_limit));
  endtask

  initial begin
    int                          r;
    int                          nframes;
    int                          deferred;
    int                          budget;
    int                          len;
    logic [tfrf_pkg::BYTE_W-1:0] b;
    logic [tfrf_pkg::BYTE_W-1:0] old_term;
    logic [tfrf_pkg::BYTE_W-1:0] new_term;
    logic [tfrf_pkg::LEN_W-1:0]  lim;
    bit                          drift_done;

    drift_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset values read back first.
    read_registers();

    // A request on an empty queue gets a single no-frame result.
    request_frame();

    // Bytes with every bit low and every bit high, then the terminator.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(tfrf_pkg::TERM_RESET);
    request_frame();

    // A frame that is only the terminator has length zero.
    push_byte(tfrf_pkg::TERM_RESET);
    request_frame();

    // A byte with no terminator behind it counts no frame; it then leads
    // the next frame.
    push_byte(8'h55);
    request_frame();
    push_byte(tfrf_pkg::TERM_RESET);
    request_frame();

    // Limit of three: the third pop is too large, before the terminator.
    settle();
    set_register(tfrf_pkg::REG_MAX_FRAME_LENGTH, 8'd3);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    push_byte(tfrf_pkg::TERM_RESET);
    request_frame();

    // A limit of zero behaves as one.
    settle();
    set_register(tfrf_pkg::REG_MAX_FRAME_LENGTH, 8'd0);
    push_byte(tfrf_pkg::TERM_RESET);
    request_frame();

    // A counted frame whose terminator no longer matches: the queue runs
    // dry and the request ends in a frame error.
    settle();
    set_register(tfrf_pkg::REG_MAX_FRAME_LENGTH, 8'd63);
    set_register(tfrf_pkg::REG_TERMINATOR_BYTE, 8'hFF);
    push_byte(8'h07);
    push_byte(8'hFF);
    settle();
    set_register(tfrf_pkg::REG_TERMINATOR_BYTE, 8'h42);
    request_frame();
    settle();
    read_registers();

    // Random part, in phases.
    while (requests_sent < REQUEST_TARGET) begin
      r       = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!drift_done && requests_sent > 150) begin
        // Frame count drift up to saturation: terminators counted under one
        // terminator value are popped as data under another. Three rounds
        // lift the count to its ceiling; the last pass fills the queue,
        // drops one push and ends in a frame error after a full queue.
        drift_done = 1'b1;
        flush_queue(6'd33);
        old_term = 8'($urandom);
        new_term = old_term ^ 8'($urandom_range(1, 255));
        repeat (3) begin
          settle();
          set_register(tfrf_pkg::REG_TERMINATOR_BYTE, old_term);
          repeat (31) push_byte(old_term);
          settle();
          set_register(tfrf_pkg::REG_TERMINATOR_BYTE, new_term);
          push_byte(new_term);
          request_frame();
        end
        settle();
        set_register(tfrf_pkg::REG_TERMINATOR_BYTE, old_term);
        repeat (33) push_byte(old_term);
        settle();
        set_register(tfrf_pkg::REG_TERMINATOR_BYTE, new_term);
        request_frame();
      end else if (r < 65) begin
        // Well-formed frames with random content. Some requests follow each
        // frame at once, others are deferred until several frames wait, and
        // now and then one request too many finds no frame.
        nframes  = $urandom_range(1, 3);
        deferred = 0;
        budget   = 20;
        repeat (nframes) begin
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 16);
          if (len > budget) len = budget;
          budget -= len;
          repeat (len) begin
            b = 8'($urandom);
            // Mostly keep the terminator out of the data; the rare one left
            // in splits the frame.
            if (b == cur_term && $urandom_range(0, 9) != 0) b = ~b;
            push_byte(b);
          end
          push_byte(cur_term);
          if ($urandom_range(0, 1) == 1)
            request_frame();
          else
            deferred++;
        end
        repeat (deferred) request_frame();
        if ($urandom_range(0, 3) == 0) request_frame();
      end else if (r < 77) begin
        // Noise: random pushes and requests from a clean queue, under a
        // random limit.
        flush_queue(6'($urandom_range(1, 33)));
        repeat ($urandom_range(1, 5)) begin
          b = ($urandom_range(0, 3) == 0) ? cur_term : 8'($urandom);
          if ($urandom_range(0, 1) == 1)
            push_byte(b);
          else
            request_frame();
        end
      end else if (r < 88) begin
        // New register setting, extremes included, then read back.
        case ($urandom_range(0, 7))
          0:       lim = 6'd0;
          1:       lim = 6'd1;
          2:       lim = 6'd33;
          3:       lim = 6'd63;
          default: lim = 6'($urandom_range(8, 33));
        endcase
        case ($urandom_range(0, 5))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          2:       b = tfrf_pkg::TERM_RESET;
          default: b = 8'($urandom);
        endcase
        flush_queue(lim);
        set_register(tfrf_pkg::REG_TERMINATOR_BYTE, b);
        read_registers();
      end else begin
        // Longest frame the queue can hold: 31 data bytes and the
        // terminator fill it, two more pushes are dropped. With a limit of
        // 32 the frame is too large, with 33 it comes through whole.
        flush_queue(($urandom_range(0, 1) == 1) ? 6'd32 : 6'd33);
        repeat (31) begin
          b = 8'($urandom);
          if (b == cur_term) b = ~b;
          push_byte(b);
        end
        push_byte(cur_term);
        repeat (2) push_byte(8'($urandom));
        request_frame();
        request_frame();
      end
    end

    // Drain: every owed result must arrive, then a quiet tail.
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tfrf_pkg.sv
rtl/tfrf_ram.sv
rtl/tfrf_regs.sv
rtl/tfrf_ctrl.sv
rtl/tfrf_datapath.sv
rtl/terminated_frame_receive_fifo.sv
dv/tfrf_frame_checker.sv
dv/terminated_frame_receive_fifo_test.sv
